>>> src/qtsp_pkg.sv
`default_nettype none

package qtsp_pkg;

  // angle fields are signed fixed point, commands are whole degrees
  localparam int ANGLE_W = 16;
  localparam int CMD_W   = 8;
  localparam int CMD_MAX = 180;
  localparam int B_ZERO  = 90;

endpackage

`default_nettype wire

>>> src/quintic_two_axis_servo_profile_unit.sv
// Quintic rest-to-rest profile for a two-axis servo arm.
// Input channel (in_valid / in_stall): start and end angles of both axes in
// signed degrees with ANGLE_FRAC_BITS fraction bits, a step index and a step
// count. Each transfer yields exactly one result transfer on the output
// channel (out_valid / out_stall): servo A command (axis zero), servo B
// command (ninety minus axis one), both whole degrees 0..180, and move_done.
// The pipeline takes one item per cycle while the skid entry is empty: a
// capture stage, one register stage per quotient bit of the step divider,
// then stages for u^2, u^3 with the blend polynomial, the blend value, the
// interpolation and the command rounding, then the output register.
// The output register is backed by a one-entry skid buffer. While the
// receiver stalls, the pipeline keeps moving until the skid entry fills;
// in_stall is that skid entry's valid bit, a register, so it does not depend
// on out_stall in the same cycle. Nothing is lost or repeated on a stall.
// Synchronous reset empties the pipeline, the skid entry and the output
// register; there is no other state.
`default_nettype none

module quintic_two_axis_servo_profile_unit
  import qtsp_pkg::*;
#(
  parameter int ANGLE_FRAC_BITS = 7,
  parameter int BLEND_FRAC_BITS = 16,
  parameter int STEP_BITS       = 12
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_valid,
  output logic                           in_stall,
  input  wire logic signed [ANGLE_W-1:0] in_start_theta0,
  input  wire logic signed [ANGLE_W-1:0] in_start_theta1,
  input  wire logic signed [ANGLE_W-1:0] in_end_theta0,
  input  wire logic signed [ANGLE_W-1:0] in_end_theta1,
  input  wire logic [STEP_BITS-1:0]      in_step_index,
  input  wire logic [STEP_BITS-1:0]      in_step_count,
  output logic                           out_valid,
  input  wire logic                      out_stall,
  output logic [CMD_W-1:0]               out_servo_a_cmd,
  output logic [CMD_W-1:0]               out_servo_b_cmd,
  output logic                           out_move_done
);

  localparam int F  = BLEND_FRAC_BITS;
  localparam int SB = STEP_BITS;
  localparam int N  = F + 6;
  localparam int DW = ANGLE_FRAC_BITS + 18;

  localparam logic [F+4:0] TEN = (F+5)'(10) << F;
  localparam logic [F+3:0] ONE = (F+4)'(1) << F;
  localparam logic signed [DW-1:0] TOP   = DW'(CMD_MAX) << ANGLE_FRAC_BITS;
  localparam logic signed [DW-1:0] B90   = DW'(B_ZERO) << ANGLE_FRAC_BITS;
  localparam logic signed [DW-1:0] HALF  = (DW'(1) << ANGLE_FRAC_BITS) >> 1;

  localparam int S_U2  = F + 1;
  localparam int S_U3  = F + 2;
  localparam int S_BL  = F + 3;
  localparam int S_LRP = F + 4;
  localparam int S_CMD = F + 5;

  typedef struct packed {
    logic signed [ANGLE_W-1:0] a0;
    logic signed [ANGLE_W-1:0] a1;
    logic signed [ANGLE_W-1:0] b0;
    logic signed [ANGLE_W-1:0] b1;
    logic [SB-1:0]             cnt;
    logic [SB-1:0]             rem;
    logic [F-1:0]              q;
    logic [F-1:0]              u2;
    logic [F-1:0]              u3;
    logic [F+3:0]              p;
    logic [F:0]                s;
    logic signed [ANGLE_W-1:0] th0;
    logic signed [ANGLE_W-1:0] th1;
    logic [CMD_W-1:0]          ca;
    logic [CMD_W-1:0]          cb;
    logic                      done;
  } stage_t;

  stage_t         pipe_r   [N];
  stage_t         pipe_nxt [N];
  logic [N-1:0]   v_r;
  stage_t         skid_r;
  logic           skid_v_r;
  stage_t         out_r;
  logic           out_valid_r;
  logic           adv;
  logic           push;

  function automatic logic [CMD_W-1:0] to_deg(input logic signed [DW-1:0] c);
    logic signed [DW-1:0] t;
    t = c;
    if (t < 0) t = '0;
    if (t > TOP) t = TOP;
    t = t + HALF;
    return CMD_W'(t >>> ANGLE_FRAC_BITS);
  endfunction

  // stage 0: capture, fix up a zero count
  always_comb begin
    pipe_nxt[0]      = pipe_r[0];
    pipe_nxt[0].a0   = in_start_theta0;
    pipe_nxt[0].a1   = in_start_theta1;
    pipe_nxt[0].b0   = in_end_theta0;
    pipe_nxt[0].b1   = in_end_theta1;
    pipe_nxt[0].cnt  = (in_step_count == '0) ? SB'(1) : in_step_count;
    pipe_nxt[0].done = in_step_index >= pipe_nxt[0].cnt;
    pipe_nxt[0].rem  = pipe_nxt[0].done ? '0 : in_step_index;
    pipe_nxt[0].q    = '0;
  end

  // restoring divider, one quotient bit per stage
  for (genvar k = 1; k <= F; k++) begin : g_div
    always_comb begin
      logic [SB:0] r2;
      r2 = {pipe_r[k-1].rem, 1'b0};
      pipe_nxt[k] = pipe_r[k-1];
      if (r2 >= {1'b0, pipe_r[k-1].cnt}) begin
        pipe_nxt[k].rem = SB'(r2 - {1'b0, pipe_r[k-1].cnt});
        pipe_nxt[k].q   = {pipe_r[k-1].q[F-2:0], 1'b1};
      end else begin
        pipe_nxt[k].rem = SB'(r2);
        pipe_nxt[k].q   = {pipe_r[k-1].q[F-2:0], 1'b0};
      end
    end
  end

  always_comb begin
    logic [2*F-1:0] sq;
    sq = pipe_r[S_U2-1].q * pipe_r[S_U2-1].q;
    pipe_nxt[S_U2]    = pipe_r[S_U2-1];
    pipe_nxt[S_U2].u2 = sq[2*F-1:F];
  end

  // u^3 and p = 10 - 15u + 6u^2 side by side
  always_comb begin
    logic [2*F-1:0] cu;
    logic [F+4:0]   pos;
    logic [F+4:0]   neg;
    cu  = pipe_r[S_U3-1].u2 * pipe_r[S_U3-1].q;
    pos = TEN + (F+5)'(pipe_r[S_U3-1].u2) * (F+5)'(6);
    neg = (F+5)'(pipe_r[S_U3-1].q) * (F+5)'(15);
    pipe_nxt[S_U3]    = pipe_r[S_U3-1];
    pipe_nxt[S_U3].u3 = cu[2*F-1:F];
    pipe_nxt[S_U3].p  = (pos >= neg) ? (F+4)'(pos - neg) : '0;
  end

  always_comb begin
    logic [2*F+3:0] bp;
    logic [F+3:0]   sh;
    bp = pipe_r[S_BL-1].u3 * pipe_r[S_BL-1].p;
    sh = bp[2*F+3:F];
    pipe_nxt[S_BL] = pipe_r[S_BL-1];
    if (pipe_r[S_BL-1].done || sh > ONE) begin
      pipe_nxt[S_BL].s = (F+1)'(ONE);
    end else begin
      pipe_nxt[S_BL].s = (F+1)'(sh);
    end
  end

  // floor shift of s*(end-start), then add start
  always_comb begin
    logic signed [ANGLE_W:0]   d0;
    logic signed [ANGLE_W:0]   d1;
    logic signed [F+18:0]      m0;
    logic signed [F+18:0]      m1;
    logic signed [F+18:0]      t0;
    logic signed [F+18:0]      t1;
    d0 = {pipe_r[S_LRP-1].b0[ANGLE_W-1], pipe_r[S_LRP-1].b0}
       - {pipe_r[S_LRP-1].a0[ANGLE_W-1], pipe_r[S_LRP-1].a0};
    d1 = {pipe_r[S_LRP-1].b1[ANGLE_W-1], pipe_r[S_LRP-1].b1}
       - {pipe_r[S_LRP-1].a1[ANGLE_W-1], pipe_r[S_LRP-1].a1};
    m0 = $signed({1'b0, pipe_r[S_LRP-1].s}) * d0;
    m1 = $signed({1'b0, pipe_r[S_LRP-1].s}) * d1;
    t0 = (m0 >>> F) + pipe_r[S_LRP-1].a0;
    t1 = (m1 >>> F) + pipe_r[S_LRP-1].a1;
    pipe_nxt[S_LRP]     = pipe_r[S_LRP-1];
    pipe_nxt[S_LRP].th0 = t0[ANGLE_W-1:0];
    pipe_nxt[S_LRP].th1 = t1[ANGLE_W-1:0];
  end

  always_comb begin
    pipe_nxt[S_CMD]    = pipe_r[S_CMD-1];
    pipe_nxt[S_CMD].ca = to_deg(DW'(pipe_r[S_CMD-1].th0));
    pipe_nxt[S_CMD].cb = to_deg(B90 - DW'(pipe_r[S_CMD-1].th1));
  end

  assign adv      = !skid_v_r;
  assign push     = adv && v_r[N-1];
  assign in_stall = skid_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (adv) begin
      v_r <= {v_r[N-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pipe_r <= pipe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      skid_v_r    <= 1'b0;
    end else if (!out_valid_r || !out_stall) begin
      out_valid_r <= skid_v_r || push;
      skid_v_r    <= 1'b0;
    end else if (push) begin
      skid_v_r <= 1'b1;
    end
  end

  // output slot refills from the skid entry first
  always_ff @(posedge clk) begin
    if (!out_valid_r || !out_stall) begin
      if (skid_v_r) begin
        out_r <= skid_r;
      end else if (push) begin
        out_r <= pipe_r[N-1];
      end
    end else if (push) begin
      skid_r <= pipe_r[N-1];
    end
  end

  assign out_valid       = out_valid_r;
  assign out_servo_a_cmd = out_r.ca;
  assign out_servo_b_cmd = out_r.cb;
  assign out_move_done   = out_r.done;

endmodule

`default_nettype wire

>>> src/qtsp_checker.sv
`default_nettype none

module qtsp_checker
  import qtsp_pkg::*;
(
  input wire logic             clk,
  input wire logic             rst_n,
  input wire logic             out_valid,
  input wire logic             out_stall,
  input wire logic [CMD_W-1:0] out_servo_a_cmd,
  input wire logic [CMD_W-1:0] out_servo_b_cmd
);

  // a stalled transfer stays put
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_servo_a_cmd)
      && $stable(out_servo_b_cmd))
    else $error("stalled result changed");

  a_range_a: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_servo_a_cmd <= CMD_W'(CMD_MAX))
    else $error("servo a command out of range");

  a_range_b: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_servo_b_cmd <= CMD_W'(CMD_MAX))
    else $error("servo b command out of range");

  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result after reset");

endmodule

bind quintic_two_axis_servo_profile_unit qtsp_checker u_qtsp_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_servo_a_cmd (out_servo_a_cmd),
  .out_servo_b_cmd (out_servo_b_cmd)
);

`default_nettype wire
